[rtl/edge_profile_peak_search_top_defines.svh]
`ifndef EDGE_PROFILE_PEAK_SEARCH_TOP_DEFINES_SVH
`define EDGE_PROFILE_PEAK_SEARCH_TOP_DEFINES_SVH

`ifndef SYNTHESIS
`define EPS_ASSERT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("eps assertion failed");
`define EPS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("eps assertion failed");
`else
`define EPS_ASSERT(lbl, ante, cons)
`define EPS_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

[rtl/eps_pkg.sv]
package eps_pkg;

  localparam int MAX_HALF_WIDTH_DEF = 31;
  localparam int COORD_WIDTH_DEF    = 13;
  localparam int QUEUE_DEPTH        = 2;

  localparam int PIX_W      = 8;
  localparam int SUM_W      = 14;
  localparam int POS_W      = 13;
  localparam int HW_W       = 5;
  localparam int THR_W      = 8;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 13;

  localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_COLOR_MODE      = 3'd0,
    REG_HALF_WIDTH      = 3'd1,
    REG_GRAD_THRESHOLD  = 3'd2,
    REG_SCAN_DESCENDING = 3'd3,
    REG_FIRST_POSITION  = 3'd4
  } cfg_reg_t;

  typedef struct packed {
    logic             color_mode;
    logic [HW_W-1:0]  half_width;
    logic [THR_W-1:0] grad_threshold;
    logic             scan_descending;
    logic [POS_W-1:0] first_position;
  } cfg_t;

  // One finished (or abandoned) cross line handed from front to back.
  typedef struct packed {
    logic [SUM_W-1:0] sum;
    logic             last_line;
    logic             last_pos;
  } line_rec_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_DIV,
    S_EVAL,
    S_EMIT
  } back_state_t;

endpackage

[rtl/eps_if.sv]
interface eps_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] before_c0;
  logic [7:0] after_c0;
  logic [7:0] before_c1;
  logic [7:0] after_c1;
  logic [7:0] before_c2;
  logic [7:0] after_c2;
  logic       last_in_line;
  logic       last_position;

  modport source (
    output valid, before_c0, after_c0, before_c1, after_c1, before_c2, after_c2,
           last_in_line, last_position,
    input  ready
  );
  modport sink (
    input  valid, before_c0, after_c0, before_c1, after_c1, before_c2, after_c2,
           last_in_line, last_position,
    output ready
  );
endinterface

interface eps_out_if;
  logic        valid;
  logic        ready;
  logic        found;
  logic [12:0] edge_position;
  logic [7:0]  edge_value;

  modport source (
    output valid, found, edge_position, edge_value,
    input  ready
  );
  modport sink (
    input  valid, found, edge_position, edge_value,
    output ready
  );
endinterface

[rtl/eps_front.sv]
module eps_front (
  input  logic              clk,
  input  logic              rst_n,
  eps_in_if.sink            in_ch,
  input  eps_pkg::cfg_t     cfg,
  input  logic              rec_full,
  output logic              rec_push,
  output eps_pkg::line_rec_t rec
);
  import eps_pkg::*;

  function automatic logic [PIX_W-1:0] abs_diff(input logic [PIX_W-1:0] a,
                                                input logic [PIX_W-1:0] b);
    return (a > b) ? (a - b) : (b - a);
  endfunction

  logic [SUM_W-1:0] line_sum_r, line_sum_nxt;
  logic [PIX_W-1:0] g0, g1, g2, g;
  logic [SUM_W:0]   sum_wide;
  logic [SUM_W-1:0] sum_sat;
  logic             take;

  assign in_ch.ready = !rec_full;
  assign take        = in_ch.valid && in_ch.ready;

  always_comb begin
    g0 = abs_diff(in_ch.before_c0, in_ch.after_c0);
    g1 = abs_diff(in_ch.before_c1, in_ch.after_c1);
    g2 = abs_diff(in_ch.before_c2, in_ch.after_c2);
    g  = g0;
    if (cfg.color_mode) begin
      if (g1 > g) g = g1;
      if (g2 > g) g = g2;
    end
  end

  assign sum_wide = (SUM_W+1)'(line_sum_r) + (SUM_W+1)'(g);
  assign sum_sat  = sum_wide[SUM_W] ? SUM_MAX : sum_wide[SUM_W-1:0];

  assign rec_push = take && (in_ch.last_in_line || in_ch.last_position);
  assign rec      = '{sum: sum_sat, last_line: in_ch.last_in_line,
                      last_pos: in_ch.last_position};

  always_comb begin
    line_sum_nxt = line_sum_r;
    if (take) begin
      line_sum_nxt = rec_push ? '0 : sum_sat;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_sum_r <= '0;
    end else begin
      line_sum_r <= line_sum_nxt;
    end
  end

endmodule

[rtl/eps_fifo.sv]
module eps_fifo #(
  parameter int DEPTH = eps_pkg::QUEUE_DEPTH
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  eps_pkg::line_rec_t din,
  output logic               full,
  input  logic               pop,
  output eps_pkg::line_rec_t dout,
  output logic               empty
);
  import eps_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  line_rec_t        mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_push, do_pop;

  assign full    = (count_r == CNT_W'(DEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

[rtl/eps_back.sv]
`include "edge_profile_peak_search_top_defines.svh"

module eps_back #(
  parameter int MAX_HALF_WIDTH = eps_pkg::MAX_HALF_WIDTH_DEF,
  parameter int COORD_WIDTH    = eps_pkg::COORD_WIDTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  eps_pkg::cfg_t      cfg,
  input  eps_pkg::line_rec_t rec,
  input  logic               rec_empty,
  output logic               rec_pop,
  eps_out_if.source          out_ch
);
  import eps_pkg::*;

  localparam int DVS_W    = $clog2(2 * MAX_HALF_WIDTH + 2);
  localparam int CNT_W    = $clog2(SUM_W);
  localparam int HW_CLAMP = (MAX_HALF_WIDTH > 31) ? 31 : MAX_HALF_WIDTH;
  localparam logic [POS_W-1:0] COORD_MASK = (COORD_WIDTH >= POS_W) ? {POS_W{1'b1}} :
                                            POS_W'((1 << COORD_WIDTH) - 1);

  back_state_t      state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [SUM_W-1:0] dvd_r, dvd_nxt;
  logic [DVS_W-1:0] rem_r, rem_nxt, dvs_r, dvs_nxt;
  logic             last_line_r, last_line_nxt, last_pos_r, last_pos_nxt;
  logic [POS_W-1:0] pc_r, pc_nxt;
  logic [PIX_W-1:0] peak_value_r, peak_value_nxt;
  logic             peak_valid_r, peak_valid_nxt, done_r, done_nxt;
  logic             res_found_r, res_found_nxt;
  logic [POS_W-1:0] res_pos_r, res_pos_nxt;
  logic [PIX_W-1:0] res_val_r, res_val_nxt;
  logic             out_valid_r, out_valid_nxt, out_found_r, out_found_nxt;
  logic [POS_W-1:0] out_pos_r, out_pos_nxt;
  logic [PIX_W-1:0] out_val_r, out_val_nxt;

  logic [HW_W-1:0]  hw_eff;
  logic [DVS_W-1:0] divisor;
  logic [DVS_W:0]   rem_sh;
  logic             ge;
  logic [PIX_W-1:0] avg;
  logic             above, report, slot_free, load_out;
  logic [POS_W-1:0] pm1, coord;

  assign hw_eff  = (int'(cfg.half_width) > MAX_HALF_WIDTH) ? HW_W'(HW_CLAMP) : cfg.half_width;
  assign divisor = DVS_W'({hw_eff, 1'b1});

  assign rem_sh = {rem_r, dvd_r[SUM_W-1]};
  assign ge     = (rem_sh >= {1'b0, dvs_r});
  assign avg    = (|dvd_r[SUM_W-1:PIX_W]) ? {PIX_W{1'b1}} : dvd_r[PIX_W-1:0];
  assign above  = (avg > cfg.grad_threshold);
  assign report = above ? (peak_valid_r && (avg < peak_value_r)) : peak_valid_r;

  assign pm1   = pc_r - 1'b1;
  assign coord = (cfg.scan_descending ? (cfg.first_position - pm1)
                                      : (cfg.first_position + pm1)) & COORD_MASK;

  assign slot_free = !out_valid_r || out_ch.ready;
  assign rec_pop   = (state_r == S_IDLE) && !rec_empty;
  assign load_out  = (state_r == S_EMIT) && slot_free;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (!rec_empty) begin
          if (!done_r && rec.last_line) begin
            state_nxt = S_DIV;
          end else if (!done_r && rec.last_pos) begin
            state_nxt = S_EMIT;
          end
        end
      end
      S_DIV: begin
        if (cnt_r == CNT_W'(SUM_W - 1)) state_nxt = S_EVAL;
      end
      S_EVAL: begin
        if (report || last_pos_r) begin
          state_nxt = S_EMIT;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_EMIT: begin
        if (slot_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // datapath and search state
  always_comb begin
    cnt_nxt        = cnt_r;
    dvd_nxt        = dvd_r;
    rem_nxt        = rem_r;
    dvs_nxt        = dvs_r;
    last_line_nxt  = last_line_r;
    last_pos_nxt   = last_pos_r;
    pc_nxt         = pc_r;
    peak_value_nxt = peak_value_r;
    peak_valid_nxt = peak_valid_r;
    done_nxt       = done_r;
    res_found_nxt  = res_found_r;
    res_pos_nxt    = res_pos_r;
    res_val_nxt    = res_val_r;
    out_valid_nxt  = out_valid_r && !out_ch.ready;
    out_found_nxt  = out_found_r;
    out_pos_nxt    = out_pos_r;
    out_val_nxt    = out_val_r;
    case (state_r)
      S_IDLE: begin
        if (!rec_empty) begin
          last_line_nxt = rec.last_line;
          last_pos_nxt  = rec.last_pos;
          dvd_nxt       = rec.sum;
          rem_nxt       = '0;
          dvs_nxt       = divisor;
          cnt_nxt       = '0;
          res_found_nxt = 1'b0;
          res_pos_nxt   = '0;
          res_val_nxt   = '0;
          if (done_r && rec.last_pos) begin
            pc_nxt         = '0;
            peak_value_nxt = '0;
            peak_valid_nxt = 1'b0;
            done_nxt       = 1'b0;
          end
        end
      end
      S_DIV: begin
        rem_nxt = ge ? DVS_W'(rem_sh - {1'b0, dvs_r}) : rem_sh[DVS_W-1:0];
        dvd_nxt = {dvd_r[SUM_W-2:0], ge};
        cnt_nxt = cnt_r + 1'b1;
      end
      S_EVAL: begin
        if (report) begin
          res_found_nxt = 1'b1;
          res_pos_nxt   = coord;
          res_val_nxt   = peak_value_r;
          done_nxt      = 1'b1;
        end else if (above) begin
          peak_value_nxt = avg;
          peak_valid_nxt = 1'b1;
        end
        pc_nxt = pc_r + 1'b1;
      end
      S_EMIT: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_found_nxt = res_found_r;
          out_pos_nxt   = res_pos_r;
          out_val_nxt   = res_val_r;
          if (last_pos_r) begin
            pc_nxt         = '0;
            peak_value_nxt = '0;
            peak_valid_nxt = 1'b0;
            done_nxt       = 1'b0;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      pc_r         <= '0;
      peak_value_r <= '0;
      peak_valid_r <= 1'b0;
      done_r       <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      pc_r         <= pc_nxt;
      peak_value_r <= peak_value_nxt;
      peak_valid_r <= peak_valid_nxt;
      done_r       <= done_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cnt_r       <= cnt_nxt;
    dvd_r       <= dvd_nxt;
    rem_r       <= rem_nxt;
    dvs_r       <= dvs_nxt;
    last_line_r <= last_line_nxt;
    last_pos_r  <= last_pos_nxt;
    res_found_r <= res_found_nxt;
    res_pos_r   <= res_pos_nxt;
    res_val_r   <= res_val_nxt;
    out_found_r <= out_found_nxt;
    out_pos_r   <= out_pos_nxt;
    out_val_r   <= out_val_nxt;
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.found         = out_found_r;
  assign out_ch.edge_position = out_pos_r;
  assign out_ch.edge_value    = out_val_r;

  `EPS_ASSERT(a_notfound_zero, out_valid_r && !out_found_r, out_pos_r == '0 && out_val_r == '0)
  `EPS_ASSERT_NEXT(a_emit_loads, load_out, out_valid_r)
  `EPS_ASSERT(a_peak_nonzero, peak_valid_r, peak_value_r != '0)
  `EPS_ASSERT(a_div_full_line, state_r == S_DIV, last_line_r && !done_r)

endmodule

[rtl/edge_profile_peak_search_top.sv]
// Edge profile peak search. Pixel pairs stream in on in_ch, one transfer per cycle
// while the two-entry line queue has room; each cross line's gradient sum is
// averaged by a bit-serial divider in the back end, which loads the line, runs one
// divide step per quotient bit and then evaluates it, adding an emit step on the
// line that emits; it takes no new line until it is done with the last one, so short
// lines can fill the queue and stall the input. Exactly one result per search
// leaves on out_ch, from an output register, found=0 with zero position and value
// if no peak was closed. Configuration is written through cfg_we/cfg_index/cfg_data;
// the user must write it only while no search is in flight; the block does not enforce it.
module edge_profile_peak_search_top #(
  parameter int MAX_HALF_WIDTH = eps_pkg::MAX_HALF_WIDTH_DEF,
  parameter int COORD_WIDTH    = eps_pkg::COORD_WIDTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  eps_in_if.sink                          in_ch,
  eps_out_if.source                       out_ch,
  input  logic                            cfg_we,
  input  logic [eps_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [eps_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import eps_pkg::*;

  cfg_t      cfg_r, cfg_nxt;
  line_rec_t push_rec, pop_rec;
  logic      rec_push, rec_full, rec_pop, rec_empty;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_COLOR_MODE:      cfg_nxt.color_mode      = cfg_data[0];
        REG_HALF_WIDTH:      cfg_nxt.half_width      = cfg_data[HW_W-1:0];
        REG_GRAD_THRESHOLD:  cfg_nxt.grad_threshold  = cfg_data[THR_W-1:0];
        REG_SCAN_DESCENDING: cfg_nxt.scan_descending = cfg_data[0];
        REG_FIRST_POSITION:  cfg_nxt.first_position  = cfg_data[POS_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  eps_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .cfg      (cfg_r),
    .rec_full (rec_full),
    .rec_push (rec_push),
    .rec      (push_rec)
  );

  eps_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (rec_push),
    .din   (push_rec),
    .full  (rec_full),
    .pop   (rec_pop),
    .dout  (pop_rec),
    .empty (rec_empty)
  );

  eps_back #(
    .MAX_HALF_WIDTH (MAX_HALF_WIDTH),
    .COORD_WIDTH    (COORD_WIDTH)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .rec       (pop_rec),
    .rec_empty (rec_empty),
    .rec_pop   (rec_pop),
    .out_ch    (out_ch)
  );

endmodule

[test/edge_profile_peak_search_top_test.sv]
module edge_profile_peak_search_top_test;
  import eps_pkg::*;

  localparam int DRAIN_CYCLES = 60;
  localparam int DRAIN_LIMIT  = 20000;
  localparam int PHASE_ITEMS  = 400;

  typedef struct packed {
    logic [PIX_W-1:0] before_c0;
    logic [PIX_W-1:0] after_c0;
    logic [PIX_W-1:0] before_c1;
    logic [PIX_W-1:0] after_c1;
    logic [PIX_W-1:0] before_c2;
    logic [PIX_W-1:0] after_c2;
    logic             last_in_line;
    logic             last_position;
  } pixel_pair_t;

  typedef struct packed {
    logic             found;
    logic [POS_W-1:0] position;
    logic [PIX_W-1:0] value;
  } edge_result_t;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  eps_in_if  in_ch ();
  eps_out_if out_ch ();

  edge_profile_peak_search_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  int send_idle_pct;
  int recv_idle_pct;
  int items_sent;
  int error_count;

  edge_result_t edge_reports_due[$];

  // shadow of the block's registers and search state
  cfg_t             regs_sh;
  logic [SUM_W-1:0] line_acc;
  logic [POS_W-1:0] lines_done;
  logic [PIX_W-1:0] peak_level;
  bit               peak_held;
  bit               search_closed;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #2000000;
    $display("simulation failed");
    $finish;
  end

  function automatic logic [PIX_W-1:0] grad_of(logic [PIX_W-1:0] a, logic [PIX_W-1:0] b);
    return (a > b) ? a - b : b - a;
  endfunction

  function automatic void clear_search();
    line_acc      = '0;
    lines_done    = '0;
    peak_level    = '0;
    peak_held     = 1'b0;
    search_closed = 1'b0;
  endfunction

  function automatic void track_edge_search(pixel_pair_t p);
    logic [PIX_W-1:0] g;
    int unsigned      total;
    int unsigned      avg;
    logic [POS_W-1:0] idx;
    edge_result_t     r;
    bit               report;
    report = 1'b0;
    if (!search_closed) begin
      g = grad_of(p.before_c0, p.after_c0);
      if (regs_sh.color_mode) begin
        if (grad_of(p.before_c1, p.after_c1) > g) g = grad_of(p.before_c1, p.after_c1);
        if (grad_of(p.before_c2, p.after_c2) > g) g = grad_of(p.before_c2, p.after_c2);
      end
      total = int'(line_acc) + int'(g);
      line_acc = (total > SUM_MAX) ? SUM_MAX : SUM_W'(total);
      if (p.last_in_line) begin
        avg = int'(line_acc) / (2 * int'(regs_sh.half_width) + 1);
        if (avg > 255) avg = 255;
        line_acc = '0;
        if (avg > regs_sh.grad_threshold) begin
          if (!peak_held || avg >= peak_level) begin
            peak_level = PIX_W'(avg);
            peak_held  = 1'b1;
          end else begin
            report = 1'b1;
          end
        end else if (peak_held) begin
          report = 1'b1;
        end
        if (report) begin
          idx = lines_done - 1'b1;
          r.found    = 1'b1;
          r.position = regs_sh.scan_descending ? regs_sh.first_position - idx
                                               : regs_sh.first_position + idx;
          r.value    = peak_level;
          edge_reports_due.push_back(r);
          search_closed = 1'b1;
        end
        lines_done = lines_done + 1'b1;
      end
    end
    if (p.last_position) begin
      if (!search_closed) edge_reports_due.push_back('0);
      clear_search();
    end
  endfunction

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    $display("%0t mismatch: %s got %0d expected %0d", $realtime, what, got, want);
    error_count++;
  endtask

  task automatic check_result();
    edge_result_t want;
    if (edge_reports_due.size() == 0) begin
      report_mismatch("unexpected transfer, position", out_ch.edge_position, 0);
      return;
    end
    want = edge_reports_due.pop_front();
    if (out_ch.found !== want.found)
      report_mismatch("found", out_ch.found, want.found);
    if (out_ch.edge_position !== want.position)
      report_mismatch("edge_position", out_ch.edge_position, want.position);
    if (out_ch.edge_value !== want.value)
      report_mismatch("edge_value", out_ch.edge_value, want.value);
  endtask

  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) check_result();
      out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  task automatic send_pair(input pixel_pair_t p);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid         <= 1'b1;
    in_ch.before_c0     <= p.before_c0;
    in_ch.after_c0      <= p.after_c0;
    in_ch.before_c1     <= p.before_c1;
    in_ch.after_c1      <= p.after_c1;
    in_ch.before_c2     <= p.before_c2;
    in_ch.after_c2      <= p.after_c2;
    in_ch.last_in_line  <= p.last_in_line;
    in_ch.last_position <= p.last_position;
    @(posedge clk);
    while (in_ch.ready !== 1'b1) @(posedge clk);
    track_edge_search(p);
    items_sent++;
  endtask

  // back end may still be busy on a line after the last report
  task automatic drain();
    int n;
    n = 0;
    in_ch.valid <= 1'b0;
    while (edge_reports_due.size() != 0 && n < DRAIN_LIMIT) begin
      @(posedge clk);
      n++;
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    case (idx)
      REG_COLOR_MODE:      regs_sh.color_mode      = val[0];
      REG_HALF_WIDTH:      regs_sh.half_width      = val[HW_W-1:0];
      REG_GRAD_THRESHOLD:  regs_sh.grad_threshold  = val[THR_W-1:0];
      REG_SCAN_DESCENDING: regs_sh.scan_descending = val[0];
      REG_FIRST_POSITION:  regs_sh.first_position  = val[POS_W-1:0];
      default: ;
    endcase
  endtask

  task automatic apply_config(input logic color, input logic [HW_W-1:0] half,
                              input logic [THR_W-1:0] thr, input logic desc,
                              input logic [POS_W-1:0] first);
    write_reg(REG_COLOR_MODE, CFG_DATA_W'(color));
    write_reg(REG_HALF_WIDTH, CFG_DATA_W'(half));
    write_reg(REG_GRAD_THRESHOLD, CFG_DATA_W'(thr));
    write_reg(REG_SCAN_DESCENDING, CFG_DATA_W'(desc));
    write_reg(REG_FIRST_POSITION, CFG_DATA_W'(first));
    cfg_we <= 1'b0;
  endtask

  function automatic pixel_pair_t pix(int b0, int a0, int b1, int a1, int b2, int a2,
                                      int end_line, int end_search);
    pixel_pair_t p;
    p.before_c0     = PIX_W'(b0);
    p.after_c0      = PIX_W'(a0);
    p.before_c1     = PIX_W'(b1);
    p.after_c1      = PIX_W'(a1);
    p.before_c2     = PIX_W'(b2);
    p.after_c2      = PIX_W'(a2);
    p.last_in_line  = 1'(end_line);
    p.last_position = 1'(end_search);
    return p;
  endfunction

  function automatic void spread(input int unsigned grad, output logic [PIX_W-1:0] x,
                                 output logic [PIX_W-1:0] y);
    int unsigned base;
    base = $urandom_range(255 - grad);
    if ($urandom_range(1)) begin
      x = PIX_W'(base);
      y = PIX_W'(base + grad);
    end else begin
      x = PIX_W'(base + grad);
      y = PIX_W'(base);
    end
  endfunction

  function automatic pixel_pair_t shaped_pair(int unsigned grad, bit end_line, bit end_search);
    pixel_pair_t p;
    int unsigned side;
    spread(grad, p.before_c0, p.after_c0);
    side = ($urandom_range(7) == 0) ? $urandom_range(255) : $urandom_range(grad);
    spread(side, p.before_c1, p.after_c1);
    side = ($urandom_range(7) == 0) ? $urandom_range(255) : $urandom_range(grad);
    spread(side, p.before_c2, p.after_c2);
    p.last_in_line  = end_line;
    p.last_position = end_search;
    return p;
  endfunction

  task automatic scan_profile(input int n_pos, input int peak_at, input int level,
                              input int slope, input bit cut_last);
    int target;
    int len;
    int grad;
    bit end_search;
    for (int pos = 0; pos < n_pos; pos++) begin
      target = level - slope * ((pos > peak_at) ? pos - peak_at : peak_at - pos);
      len = ($urandom_range(9) == 0) ? int'($urandom_range(8, 1))
                                     : 2 * int'(regs_sh.half_width) + 1;
      for (int k = 0; k < len; k++) begin
        grad = target + int'($urandom_range(6)) - 3;
        if (grad < 0) grad = 0;
        if (grad > 255) grad = 255;
        end_search = (pos == n_pos - 1) && (k == len - 1);
        send_pair(shaped_pair(grad, (k == len - 1) && !(end_search && cut_last), end_search));
      end
    end
  endtask

  task automatic noise_search();
    int n;
    pixel_pair_t p;
    n = $urandom_range(20, 1);
    for (int i = 0; i < n; i++) begin
      p = pixel_pair_t'({$urandom, $urandom});
      p.last_in_line  = ($urandom_range(2) == 0);
      p.last_position = (i == n - 1);
      send_pair(p);
    end
  endtask

  task automatic random_search();
    int n_pos;
    int level;
    if ($urandom_range(5) == 0) begin
      noise_search();
    end else begin
      n_pos = (regs_sh.half_width > 7) ? int'($urandom_range(4, 2)) : int'($urandom_range(12, 3));
      level = ($urandom_range(4) == 0) ? int'($urandom_range(255))
                                       : int'(regs_sh.grad_threshold) + int'($urandom_range(80, 1));
      if (level > 255) level = 255;
      scan_profile(n_pos, int'($urandom_range(n_pos - 1)), level, int'($urandom_range(40)),
                   $urandom_range(7) == 0);
    end
  endtask

  task automatic random_config();
    logic [HW_W-1:0]  half;
    logic [THR_W-1:0] thr;
    logic [POS_W-1:0] first;
    half = ($urandom_range(7) == 0) ? HW_W'($urandom_range(31, 8)) : HW_W'($urandom_range(3));
    case ($urandom_range(7))
      0:       thr = '0;
      1:       thr = '1;
      default: thr = THR_W'($urandom_range(200));
    endcase
    if ($urandom_range(3) == 0)
      first = $urandom_range(1) ? POS_W'($urandom_range(3)) : POS_W'(8191 - $urandom_range(3));
    else
      first = POS_W'($urandom_range(8191));
    apply_config(1'($urandom_range(1)), half, thr, 1'($urandom_range(1)), first);
  endtask

  task automatic test_directed_colour();
    apply_config(1'b1, 5'd0, 8'd10, 1'b0, 13'd8190);
    // channel 1 wins, channel 2 wins, plateau, drop; coordinate wraps past the top
    send_pair(pix(0, 5, 0, 20, 3, 0, 1, 0));
    send_pair(pix(9, 9, 1, 1, 40, 0, 1, 0));
    send_pair(pix(40, 0, 0, 0, 0, 0, 1, 0));
    send_pair(pix(0, 30, 0, 0, 0, 0, 1, 0));
    send_pair(pix(255, 0, 0, 255, 255, 0, 1, 0));
    send_pair(pix(0, 0, 0, 0, 0, 0, 0, 1));
    // peak closed by a fall below the threshold, then a silent search end
    send_pair(pix(0, 255, 255, 0, 0, 255, 1, 0));
    send_pair(pix(3, 8, 0, 0, 0, 0, 1, 0));
    send_pair(pix(7, 7, 0, 0, 0, 0, 0, 1));
    // still rising at the last position
    send_pair(pix(20, 0, 0, 0, 0, 0, 1, 0));
    send_pair(pix(0, 30, 0, 0, 0, 0, 1, 0));
    send_pair(pix(40, 0, 0, 0, 0, 0, 1, 1));
    // average equal to the threshold is no edge
    send_pair(pix(0, 10, 0, 0, 0, 0, 1, 1));
    drain();
  endtask

  task automatic test_directed_gray();
    apply_config(1'b0, 5'd1, 8'd0, 1'b1, 13'd1);
    // channels 1 and 2 must be ignored; average clips to 255
    send_pair(pix(0, 255, 255, 0, 0, 255, 0, 0));
    send_pair(pix(255, 0, 0, 255, 255, 0, 0, 0));
    send_pair(pix(0, 255, 255, 0, 0, 255, 0, 0));
    send_pair(pix(255, 0, 0, 0, 0, 0, 1, 0));
    send_pair(pix(0, 255, 0, 0, 0, 0, 0, 0));
    send_pair(pix(255, 0, 0, 0, 0, 0, 0, 0));
    send_pair(pix(9, 9, 0, 0, 0, 0, 1, 0));
    send_pair(pix(9, 9, 0, 0, 0, 0, 0, 1));
    // short line, then a line cut off by the search end
    send_pair(pix(0, 255, 0, 0, 0, 0, 0, 0));
    send_pair(pix(255, 0, 0, 0, 0, 0, 1, 0));
    send_pair(pix(0, 255, 0, 0, 0, 0, 0, 0));
    send_pair(pix(0, 255, 0, 0, 0, 0, 0, 1));
    drain();
  endtask

  task automatic test_oversized_line();
    apply_config(1'b0, 5'd0, 8'd0, 1'b0, 13'd0);
    for (int k = 0; k < 70; k++) send_pair(shaped_pair(255, k == 69, 1'b0));
    send_pair(shaped_pair(0, 1'b1, 1'b0));
    send_pair(shaped_pair($urandom_range(255), 1'b0, 1'b1));
    drain();
  endtask

  task automatic test_random_profiles();
    int setting;
    int goal;
    int searches;
    setting = 0;
    for (int phase = 0; phase < 3; phase++) begin
      send_idle_pct = (phase == 0) ? 24 : (phase == 1) ? 71 : 0;
      recv_idle_pct = (phase == 0) ? 71 : (phase == 1) ? 24 : 0;
      goal = items_sent + PHASE_ITEMS;
      while (items_sent < goal) begin
        drain();
        case (setting)
          0:       apply_config(1'b1, 5'd31, 8'd255, 1'b1, 13'd0);
          1:       apply_config(1'b0, 5'd0, 8'd0, 1'b0, 13'd8191);
          2:       apply_config(1'b1, 5'd0, 8'd0, 1'b1, 13'd0);
          3:       apply_config(1'b0, 5'd31, 8'd0, 1'b0, 13'd8190);
          default: random_config();
        endcase
        setting++;
        searches = (regs_sh.half_width > 7) ? 1 : int'($urandom_range(4, 2));
        repeat (searches) random_search();
      end
    end
    drain();
  endtask

  initial begin
    edge_result_t leftover;
    rst_n               = 1'b0;
    cfg_we              = 1'b0;
    cfg_index           = '0;
    cfg_data            = '0;
    in_ch.valid         = 1'b0;
    in_ch.before_c0     = '0;
    in_ch.after_c0      = '0;
    in_ch.before_c1     = '0;
    in_ch.after_c1      = '0;
    in_ch.before_c2     = '0;
    in_ch.after_c2      = '0;
    in_ch.last_in_line  = 1'b0;
    in_ch.last_position = 1'b0;
    send_idle_pct       = 24;
    recv_idle_pct       = 71;
    items_sent          = 0;
    error_count         = 0;
    regs_sh             = '0;
    clear_search();
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    test_directed_colour();
    test_directed_gray();
    test_oversized_line();
    test_random_profiles();

    while (edge_reports_due.size() != 0) begin
      leftover = edge_reports_due.pop_front();
      report_mismatch("missing transfer, position", 0, leftover.position);
    end
    if (error_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
